### rtl/model_device_fixed_assigner_macros.svh
// ----------------------------------------------------------------------------
// model_device_fixed_assigner_macros
// assertion macros shared by the assigner rtl
// ----------------------------------------------------------------------------
`ifndef MODEL_DEVICE_FIXED_ASSIGNER_MACROS_SVH
`define MODEL_DEVICE_FIXED_ASSIGNER_MACROS_SVH

// same-cycle implication under reset
`define MDFA_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication under reset
`define MDFA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### rtl/mdfa_pkg.sv
// ----------------------------------------------------------------------------
// mdfa_pkg
// sizes, op codes and shared types of the model device fixed assigner
// ----------------------------------------------------------------------------
package mdfa_pkg;

	// table sizes
	localparam int MAX_MODELS  = 16;
	localparam int NUM_DEVICES = 4;

	localparam int MODEL_W = $clog2(MAX_MODELS);
	localparam int PTR_W   = MODEL_W + 1;
	localparam int DEV_W   = $clog2(NUM_DEVICES);
	localparam int POP_W   = $clog2(NUM_DEVICES + 1);
	localparam int CNT_W   = $clog2(MAX_MODELS + 1);

	// fixed field widths of the channels
	localparam int FLD_OP_W    = 2;
	localparam int FLD_MODEL_W = 4;
	localparam int FLD_MASK_W  = 4;
	localparam int FLD_DEV_W   = 2;
	localparam int FLD_CNT_W   = 5;

	// op codes
	localparam logic [FLD_OP_W-1:0] OP_LOAD     = 2'd0;
	localparam logic [FLD_OP_W-1:0] OP_ASSIGN   = 2'd1;
	localparam logic [FLD_OP_W-1:0] OP_DISPATCH = 2'd2;

	// table access from the sequencer
	typedef struct packed {
		logic                   rd_en;
		logic [MODEL_W-1:0]     rd_idx;
		logic                   sup_we;
		logic [MODEL_W-1:0]     sup_idx;
		logic [NUM_DEVICES-1:0] sup_mask;
		logic                   fix_we;
		logic [MODEL_W-1:0]     fix_idx;
		logic [DEV_W-1:0]       fix_dev;
	} store_req_t;

	// registered read data, empty for models never loaded
	typedef struct packed {
		logic [NUM_DEVICES-1:0] mask;
		logic [DEV_W-1:0]       fixed;
	} store_rd_t;

	// best candidate of the current scan
	typedef struct packed {
		logic               vld;
		logic [POP_W-1:0]   pop;
		logic [MODEL_W-1:0] idx;
	} best_t;

	// result item
	typedef struct packed {
		logic [FLD_DEV_W-1:0]   device;
		logic [FLD_MODEL_W-1:0] out_model;
		logic                   status;
		logic [FLD_CNT_W-1:0]   assigned_count;
	} out_item_t;

endpackage

### rtl/mdfa_if.sv
// ----------------------------------------------------------------------------
// mdfa_if
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface mdfa_req_if;
	import mdfa_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [FLD_OP_W-1:0]    op;
	logic [FLD_MODEL_W-1:0] model_num;
	logic [FLD_MASK_W-1:0]  support_mask;
	logic                   device_given;
	logic [FLD_DEV_W-1:0]   job_device;

	modport source (output valid, op, model_num, support_mask, device_given, job_device,
		input ready);
	modport sink (input valid, op, model_num, support_mask, device_given, job_device,
		output ready);
endinterface

interface mdfa_rsp_if;
	import mdfa_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [FLD_DEV_W-1:0]   device;
	logic [FLD_MODEL_W-1:0] out_model;
	logic                   status;
	logic [FLD_CNT_W-1:0]   assigned_count;

	modport source (output valid, device, out_model, status, assigned_count, input ready);
	modport sink (input valid, device, out_model, status, assigned_count, output ready);
endinterface

### rtl/mdfa_pick.sv
// ----------------------------------------------------------------------------
// mdfa_pick
// shared compare unit: support count of one model and best-candidate test
// ----------------------------------------------------------------------------
module mdfa_pick (
	input  logic [mdfa_pkg::NUM_DEVICES-1:0] mask,
	input  logic [mdfa_pkg::DEV_W-1:0]       dev,
	input  logic                             remaining,
	input  mdfa_pkg::best_t                  best,
	output logic [mdfa_pkg::POP_W-1:0]       pop,
	output logic                             better
);
	import mdfa_pkg::*;

	// number of supporting devices
	always_comb begin
		pop = '0;
		for (int i = 0; i < NUM_DEVICES; i++) begin
			pop = pop + POP_W'(mask[i]);
		end
	end

	// strictly fewer devices wins, so ties keep the lower id seen first
	assign better = remaining && mask[dev] && (!best.vld || (pop < best.pop));

endmodule

### rtl/mdfa_store.sv
// ----------------------------------------------------------------------------
// mdfa_store
// support mask and fixed device tables with present and written bits
// ----------------------------------------------------------------------------
module mdfa_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mdfa_pkg::store_req_t sreq,
	output mdfa_pkg::store_rd_t  srd
);
	import mdfa_pkg::*;

	logic [NUM_DEVICES-1:0] sup_mem [MAX_MODELS];
	logic [DEV_W-1:0]       fix_mem [MAX_MODELS];

	logic [MAX_MODELS-1:0]  present_q;
	logic [MAX_MODELS-1:0]  fix_vld_q;
	logic [NUM_DEVICES-1:0] mask_rd_q;
	logic [DEV_W-1:0]       fix_rd_q;
	logic                   pres_rd_q;
	logic                   fixv_rd_q;

	// table writes and registered reads
	always_ff @(posedge clk) begin
		if (sreq.sup_we) begin
			sup_mem[sreq.sup_idx] <= sreq.sup_mask;
		end
		if (sreq.fix_we) begin
			fix_mem[sreq.fix_idx] <= sreq.fix_dev;
		end
		if (sreq.rd_en) begin
			mask_rd_q <= sup_mem[sreq.rd_idx];
			fix_rd_q  <= fix_mem[sreq.rd_idx];
		end
	end

	// per-entry valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			fix_vld_q <= '0;
			pres_rd_q <= 1'b0;
			fixv_rd_q <= 1'b0;
		end else begin
			if (sreq.sup_we) begin
				present_q[sreq.sup_idx] <= 1'b1;
			end
			if (sreq.fix_we) begin
				fix_vld_q[sreq.fix_idx] <= 1'b1;
			end
			if (sreq.rd_en) begin
				pres_rd_q <= present_q[sreq.rd_idx];
				fixv_rd_q <= fix_vld_q[sreq.rd_idx];
			end
		end
	end

	// unwritten entries read as their reset value
	assign srd.mask  = pres_rd_q ? mask_rd_q : '0;
	assign srd.fixed = fixv_rd_q ? fix_rd_q : '0;

endmodule

### rtl/model_device_fixed_assigner.sv
// ----------------------------------------------------------------------------
// model_device_fixed_assigner
// keeps per-model device support, fixes one device per model, answers jobs
// ----------------------------------------------------------------------------
// Usage:
// req carries one command per transfer: load a model's support mask, run the
// assignment, or dispatch a job. rsp returns exactly one item per command.
// req.ready is high only while the sequencer is idle; one command is worked
// on at a time.
// Load, dispatch and unknown ops: the sequencer moves to ST_DISP or ST_RESP,
// then loads the result into the output register, which raises rsp.valid (a
// dispatch waits for the registered table read); the next command is taken
// once it is back in idle. Assignment: one pass over the support table builds
// the remaining set, then a device pointer step and a scan pass alternate until
// every supported model is fixed (at most MAX_MODELS*NUM_DEVICES scan passes);
// one compare unit visits one model per cycle. ST_RESP follows the last step.
// The result sits in an output register: a new command is taken while it
// waits, and a stalled rsp only holds the next result back in the sequencer.
// Reset (arst_n low) clears all tables to empty, fixed devices to device 0
// and the last assignment count to zero, and drops any pending result.
// ----------------------------------------------------------------------------
`include "model_device_fixed_assigner_macros.svh"

module model_device_fixed_assigner (
	input  logic       clk,
	input  logic       arst_n,
	mdfa_req_if.sink   req,
	mdfa_rsp_if.source rsp
);
	import mdfa_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DISP = 3'd1;
	localparam logic [2:0] ST_INIT = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_STEP = 3'd4;
	localparam logic [2:0] ST_RESP = 3'd5;

	localparam logic [PTR_W-1:0] PTR_END = PTR_W'(MAX_MODELS);

	logic [2:0]             state_q;
	logic [PTR_W-1:0]       ptr_q;
	logic [MAX_MODELS-1:0]  remaining_q;
	logic [CNT_W-1:0]       picked_q;
	logic [CNT_W-1:0]       last_count_q;
	logic [DEV_W-1:0]       dev_q;
	best_t                  best_q;
	logic [FLD_MODEL_W-1:0] model_q;
	logic                   given_q;
	logic [FLD_DEV_W-1:0]   jdev_q;
	out_item_t              res_q;
	out_item_t              out_q;
	logic                   out_valid_q;

	logic                   accept;
	logic                   in_range;
	logic                   pass_end;
	logic                   data_vld;
	logic [MODEL_W-1:0]     cur_idx;
	logic [MAX_MODELS-1:0]  rem_next;
	logic [CNT_W-1:0]       cnt_next;
	logic [DEV_W-1:0]       dev_next;
	logic                   out_free;
	logic                   load_out;
	logic [POP_W-1:0]       pop;
	logic                   better;
	logic [DEV_W-1:0]       disp_dev;
	out_item_t              disp_res;
	out_item_t              result;
	store_req_t             sreq;
	store_rd_t              srd;

	// handshake and pass bookkeeping
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_range  = int'(req.model_num) < MAX_MODELS;
	assign pass_end  = (ptr_q == PTR_END);
	assign data_vld  = (ptr_q != '0);
	assign cur_idx   = MODEL_W'(ptr_q - PTR_W'(1));
	assign out_free  = !out_valid_q || rsp.ready;
	assign load_out  = ((state_q == ST_DISP) || (state_q == ST_RESP)) && out_free;

	// effect of one device pointer step
	always_comb begin
		rem_next = remaining_q;
		if (best_q.vld) begin
			rem_next = remaining_q & ~(MAX_MODELS'(1) << best_q.idx);
		end
		cnt_next = picked_q + CNT_W'(best_q.vld);
		dev_next = (int'(dev_q) == NUM_DEVICES - 1) ? '0 : dev_q + DEV_W'(1);
	end

	// table access
	always_comb begin
		sreq.rd_en    = accept || (((state_q == ST_INIT) || (state_q == ST_SCAN)) && !pass_end);
		sreq.rd_idx   = (state_q == ST_IDLE) ? MODEL_W'(req.model_num) : MODEL_W'(ptr_q);
		sreq.sup_we   = accept && (req.op == OP_LOAD) && in_range;
		sreq.sup_idx  = MODEL_W'(req.model_num);
		sreq.sup_mask = NUM_DEVICES'(req.support_mask);
		sreq.fix_we   = (state_q == ST_STEP) && best_q.vld;
		sreq.fix_idx  = best_q.idx;
		sreq.fix_dev  = dev_q;
	end

	mdfa_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.sreq   (sreq),
		.srd    (srd)
	);

	mdfa_pick u_pick (
		.mask      (srd.mask),
		.dev       (dev_q),
		.remaining (remaining_q[cur_idx]),
		.best      (best_q),
		.pop       (pop),
		.better    (better)
	);

	// dispatch answer from the registered table read
	always_comb begin
		if (given_q && (int'(jdev_q) < NUM_DEVICES)) begin
			disp_dev = DEV_W'(jdev_q);
		end else begin
			disp_dev = srd.fixed;
		end
		disp_res.out_model      = model_q;
		disp_res.assigned_count = FLD_CNT_W'(last_count_q);
		if (int'(model_q) < MAX_MODELS) begin
			disp_res.device = FLD_DEV_W'(disp_dev);
			disp_res.status = !srd.mask[disp_dev];
		end else begin
			disp_res.device = '0;
			disp_res.status = 1'b1;
		end
		result = (state_q == ST_DISP) ? disp_res : res_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ptr_q        <= '0;
			remaining_q  <= '0;
			picked_q     <= '0;
			last_count_q <= '0;
			dev_q        <= '0;
			best_q       <= '0;
			model_q      <= '0;
			given_q      <= 1'b0;
			jdev_q       <= '0;
			res_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						model_q <= req.model_num;
						given_q <= req.device_given;
						jdev_q  <= req.job_device;
						res_q.device         <= '0;
						res_q.out_model      <= req.model_num;
						res_q.status         <= 1'b0;
						res_q.assigned_count <= FLD_CNT_W'(last_count_q);
						case (req.op)
							OP_ASSIGN: begin
								ptr_q       <= '0;
								remaining_q <= '0;
								picked_q    <= '0;
								// the step after the init pass wraps this to device 0
								dev_q       <= DEV_W'(NUM_DEVICES - 1);
								best_q      <= '0;
								state_q     <= ST_INIT;
							end
							OP_DISPATCH: state_q <= ST_DISP;
							default: state_q <= ST_RESP;
						endcase
					end
				end
				ST_INIT: begin
					// models with a non-empty mask join the remaining set
					if (data_vld) begin
						remaining_q[cur_idx] <= |srd.mask;
					end
					if (pass_end) begin
						state_q <= ST_STEP;
					end else begin
						ptr_q <= ptr_q + PTR_W'(1);
					end
				end
				ST_SCAN: begin
					if (data_vld && better) begin
						best_q.vld <= 1'b1;
						best_q.pop <= pop;
						best_q.idx <= cur_idx;
					end
					if (pass_end) begin
						state_q <= ST_STEP;
					end else begin
						ptr_q <= ptr_q + PTR_W'(1);
					end
				end
				ST_STEP: begin
					remaining_q <= rem_next;
					picked_q    <= cnt_next;
					dev_q       <= dev_next;
					ptr_q       <= '0;
					best_q      <= '0;
					if (rem_next == '0) begin
						last_count_q         <= cnt_next;
						res_q.assigned_count <= FLD_CNT_W'(cnt_next);
						state_q              <= ST_RESP;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_DISP, ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				out_q       <= result;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.device         = out_q.device;
	assign rsp.out_model      = out_q.out_model;
	assign rsp.status         = out_q.status;
	assign rsp.assigned_count = out_q.assigned_count;

	// checks
	`MDFA_ASSERT_IMPLIES(a_best_is_remaining, clk, arst_n, ((state_q == ST_STEP) && best_q.vld), remaining_q[best_q.idx])
	`MDFA_ASSERT_NEXT(a_scan_keeps_set, clk, arst_n, (state_q == ST_SCAN), ($stable(remaining_q) && $stable(picked_q)))
	`MDFA_ASSERT_IMPLIES(a_picked_bound, clk, arst_n, (state_q == ST_STEP), (picked_q <= CNT_W'(MAX_MODELS)))
	`MDFA_ASSERT_IMPLIES(a_best_supported, clk, arst_n, ((state_q == ST_SCAN) && best_q.vld), (best_q.pop != '0))

endmodule
